>>> sv/sdds_pkg.sv
// Shared definitions for the sine DDS DAC generator: register map codes,
// fixed field widths and the quarter-wave sine generator used to build the ROM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdds_pkg;

    // APB map: three 32-bit registers at byte offsets 0, 4 and 8
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_AMPLITUDE  = 2'd1,
        REG_OFFSET     = 2'd2
    } t_reg_idx;

    localparam int STEP_W = 32;
    localparam int AMP_W  = 17;   // signed Q9.8
    localparam int OFFS_W = 18;   // signed Q10.8
    localparam int SINE_W = 15;   // magnitude of a Q1.15 sine
    localparam int TOTAL_W = 35;  // offset*2^15 + amplitude*sine, with headroom
    localparam int RND_W   = 12;  // rounded counts, signed

    localparam logic [OFFS_W-1:0] OFFSET_RESET = 18'd32768;  // 128 counts

    // Polynomial sine of a quarter turn; x is Q15 of a quarter turn (0..32768).
    // Evaluated only while the ROM contents are built at elaboration.
    function automatic logic [SINE_W-1:0] sine_quarter(input int unsigned x);
        longint x2;
        longint u;
        longint v;
        longint y;
        x2 = (longint'(x) * longint'(x) + 64'sd16384) >>> 15;
        u  = 64'sd21024 - ((64'sd2320 * x2) >>> 15);
        v  = 64'sd51472 - ((u * x2) >>> 15);
        y  = (v * longint'(x) + 64'sd16384) >>> 15;
        if (y > 64'sd32767) begin
            y = 64'sd32767;
        end
        return SINE_W'(y);
    endfunction

endpackage

`default_nettype wire

>>> sv/sine_dds_dac_generator.sv
// Top level of the sine DDS DAC generator: APB register file, phase
// accumulator, quarter-wave sine ROM, scaling multiply and round/saturate.
// Depends on sdds_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Sine DDS for an 8-bit DAC. Every word accepted on the input channel yields
// one DAC code: offset + amplitude * sin(phase), rounded to nearest (ties up)
// and saturated to 0..255, with a clipped flag and a last flag on every
// NUM_SAMPLES-th code. The block takes one word per clock and keeps that
// rate under output stall as long as its three internal stages have room;
// o_valid rises once the word has passed through three registered stages.
// The phase accumulator and run counter update in the accept cycle; the ROM
// read, the single 17x16 multiply and the round/saturate each own one
// registered stage. The ROM holds a quarter wave plus its end point
// (2^(SINE_ADDR_BITS-2)+1 entries) and needs no clearing pass. The user
// must set registers through APB only while the block is idle; the block
// itself does not enforce this. Reads return the register value sign extended.
module sine_dds_dac_generator #(
    parameter int NUM_SAMPLES    = 360,
    parameter int SINE_ADDR_BITS = 10,
    parameter int PHASE_BITS     = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // APB configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sdds_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output      logic [31:0]                 prdata,
    output      logic                        pready,
    // tick channel
    input  wire logic                        i_valid,
    output      logic                        o_stall,
    input  wire logic                        i_restart,
    // sample channel
    output      logic                        o_valid,
    input  wire logic                        i_stall,
    output      logic [7:0]                  o_sample,
    output      logic                        o_clipped,
    output      logic                        o_last
);
    import sdds_pkg::*;

    localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);
    localparam int K_W     = SINE_ADDR_BITS - 1;          // 0..QUARTER inclusive
    localparam logic [K_W-1:0] QUARTER_K = K_W'(QUARTER);
    localparam int IDX_W   = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SAMPLES - 1);

    typedef logic [SINE_W-1:0] t_sine_rom [QUARTER+1];

    function automatic t_sine_rom f_build_rom();
        t_sine_rom rom;
        for (int k = 0; k <= QUARTER; k++) begin
            rom[k] = sine_quarter(k << (17 - SINE_ADDR_BITS));
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_rom();

    // ---------------- configuration registers ----------------
    logic [STEP_W-1:0]        r_phase_step;
    logic signed [AMP_W-1:0]  r_amplitude;
    logic signed [OFFS_W-1:0] r_offset;
    logic                     w_cfg_wr;
    t_reg_idx                 w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[REG_IDX_W+1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_amplitude  <= '0;
            r_offset     <= OFFSET_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_PHASE_STEP: r_phase_step <= pwdata;
                REG_AMPLITUDE:  r_amplitude  <= pwdata[AMP_W-1:0];
                REG_OFFSET:     r_offset     <= pwdata[OFFS_W-1:0];
                default: ;      // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_PHASE_STEP: prdata = r_phase_step;
            REG_AMPLITUDE:  prdata = {{(32-AMP_W){r_amplitude[AMP_W-1]}}, r_amplitude};
            REG_OFFSET:     prdata = {{(32-OFFS_W){r_offset[OFFS_W-1]}}, r_offset};
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    // Each stage fills when empty or when its successor moves on.
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic w_acc, w_ld2, w_ld3;

    assign w_rdy3  = !r_v3 || !i_stall;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;
    assign w_acc   = i_valid && w_rdy1;
    assign w_ld2   = r_v1 && w_rdy2;
    assign w_ld3   = r_v2 && w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_acc || (r_v1 && !w_rdy2);
            r_v2 <= w_ld2 || (r_v2 && !w_rdy3);
            r_v3 <= w_ld3 || (r_v3 && i_stall);
        end
    end

    // ---------------- stage 0: phase and run position ----------------
    logic [PHASE_BITS-1:0]     r_phase, n_phase;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [PHASE_BITS-1:0]     w_cur_phase;
    logic [PHASE_BITS-1:0]     w_step_inc;
    logic [IDX_W-1:0]          w_cur_idx;
    logic [SINE_ADDR_BITS-1:0] w_addr;
    logic [K_W-1:0]            w_j;
    logic [K_W-1:0]            w_k;
    logic                      w_last;

    assign w_step_inc  = r_phase_step[STEP_W-1 -: PHASE_BITS];
    assign w_cur_phase = i_restart ? '0 : r_phase;
    assign w_cur_idx   = i_restart ? '0 : r_idx;
    assign w_addr      = w_cur_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign w_j         = {1'b0, w_addr[SINE_ADDR_BITS-3:0]};
    // odd quadrants run the quarter wave backwards, reaching its end point
    assign w_k         = w_addr[SINE_ADDR_BITS-2] ? (QUARTER_K - w_j) : w_j;
    assign w_last      = (w_cur_idx == LAST_IDX);
    assign n_phase     = w_cur_phase + w_step_inc;
    assign n_idx       = (w_cur_idx >= LAST_IDX) ? '0 : (w_cur_idx + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_idx   <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    // ---------------- stage 1: registered ROM read ----------------
    logic [SINE_W-1:0] r_sine1;
    logic              r_neg1;
    logic              r_last1;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_sine1 <= SINE_ROM[w_k];
            r_neg1  <= w_addr[SINE_ADDR_BITS-1];
            r_last1 <= w_last;
        end
    end

    // ---------------- stage 2: scale and offset (Q.23) ----------------
    logic signed [SINE_W:0]         w_sine;
    logic signed [AMP_W+SINE_W:0]   w_prod;
    logic signed [OFFS_W+14:0]      w_offs;
    logic signed [TOTAL_W-1:0]      r_total2;
    logic                           r_last2;

    assign w_sine = r_neg1 ? -$signed({1'b0, r_sine1}) : $signed({1'b0, r_sine1});
    assign w_prod = r_amplitude * w_sine;
    assign w_offs = {r_offset, 15'b0};

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_total2 <= {{(TOTAL_W-AMP_W-SINE_W-1){w_prod[AMP_W+SINE_W]}}, w_prod}
                      + {{(TOTAL_W-OFFS_W-15){w_offs[OFFS_W+14]}}, w_offs};
            r_last2  <= r_last1;
        end
    end

    // ---------------- stage 3: round and saturate ----------------
    logic signed [TOTAL_W-1:0] w_biased;
    logic signed [RND_W-1:0]   w_rnd;
    logic                      w_under;
    logic                      w_over;
    logic [7:0]                r_sample;
    logic                      r_clipped;
    logic                      r_last3;

    assign w_biased = r_total2 + TOTAL_W'(1 << 22);
    assign w_rnd    = w_biased[TOTAL_W-1 -: RND_W];   // floor of /2^23
    assign w_under  = w_rnd[RND_W-1];
    assign w_over   = !w_under && (w_rnd[RND_W-2:8] != '0);

    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r_sample  <= w_under ? 8'h00 : (w_over ? 8'hFF : w_rnd[7:0]);
            r_clipped <= w_under || w_over;
            r_last3   <= r_last2;
        end
    end

    assign o_valid   = r_v3;
    assign o_sample  = r_sample;
    assign o_clipped = r_clipped;
    assign o_last    = r_last3;

    // ---------------- assertions ----------------
    a_clip_rails : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> (o_sample == 8'h00 || o_sample == 8'hFF))
        else $error("clipped code off the rails");

    a_idx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("run position beyond run length");

    a_restart_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_restart && !w_cfg_wr |=> r_phase == w_step_inc)
        else $error("restart did not clear phase");

    a_empty_takes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("input stalled with empty first stage");

    a_out_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r_v3 |=> r_v3)
        else $error("result lost between stages");

endmodule

`default_nettype wire
